### design/assert_macros.svh
// assertion macros shared by the design files
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ITOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define ITOA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define ITOA_ASSERT(lbl, prop, msg)
`define ITOA_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### design/itoa_pkg.sv
// shared constants and the digit glyph function for the radix ascii converter
// no dependencies
package itoa_pkg;

  localparam int CHAR_W = 8;
  localparam int LEN_W  = 8;   // covers total length and buffer size arithmetic

  localparam logic [4:0] BASE_MIN = 5'd2;
  localparam logic [4:0] BASE_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h57;  // 'a' minus ten

  // lowercase hex glyph for one digit
  function automatic logic [CHAR_W-1:0] glyph(input logic [3:0] d);
    logic [CHAR_W-1:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + CHAR_W'(d);
    end else begin
      r = CH_ALPHA + CHAR_W'(d);
    end
    return r;
  endfunction

endpackage

### design/itoa_in_if.sv
// input channel of the radix ascii converter: valid, ready and request fields
// depends on itoa_pkg
interface itoa_in_if
  import itoa_pkg::*;
#(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [VALUE_BITS-1:0] value;
  logic [4:0]            base;
  logic [5:0]            pad_width;
  logic [6:0]            buf_size;

  modport source (output valid, output operation, output value, output base,
                  output pad_width, output buf_size, input ready);
  modport sink   (input valid, input operation, input value, input base,
                  input pad_width, input buf_size, output ready);
endinterface

// output channel: one item per character, then a final terminator item
interface itoa_out_if
  import itoa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              char_valid;
  logic [5:0]        full_length;
  logic              last;

  modport source (output valid, output out_char, output char_valid,
                  output full_length, output last, input ready);
  modport sink   (input valid, input out_char, input char_valid,
                  input full_length, input last, output ready);
endinterface

### design/itoa_ram.sv
// generic single write port ram with registered read
// no dependencies
module itoa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### design/integer_to_radix_ascii.sv
// top level of the integer to radix ascii converter
// depends on itoa_pkg, itoa_in_if, itoa_out_if, itoa_ram and assert_macros.svh
//
// usage:
//   in_i takes one request item (mode, value, base, minimum width, buffer size).
//   out_o returns one item per written character, most significant first, then
//   a final item with last set that carries the NUL (char_valid clear when the
//   buffer size is zero) and the untruncated length modulo 64.
// timing:
//   the magnitude is long-divided by the base, four quotient bits per cycle, in
//   the shared divide unit. S_LEN then sizes the string, then each character
//   passes through S_RD (digit ram read) and S_CH (output load), and the
//   terminator through S_RD and S_FIN. the divide loop dominates, worst case
//   base 2 with a sign. in_i is ready only while the block is idle.
// reset:
//   rst_ni clears the sequencer and the output register; the digit ram is not
//   cleared, every digit is written before it is read.
// stalls:
//   a held output item freezes the emit sequence; the final item may still wait
//   in the output register while the next request is accepted.
`include "assert_macros.svh"

module integer_to_radix_ascii
  import itoa_pkg::*;
#(
  parameter int MAX_WIDTH  = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itoa_in_if.sink    in_i,
  itoa_out_if.source out_o
);

  localparam int QW  = ((VALUE_BITS + 3) / 4) * 4;  // dividend padded to whole chunks
  localparam int NCH = QW / 4;                      // chunks per digit
  localparam int CHW = $clog2(NCH);
  localparam int AW  = $clog2(VALUE_BITS);
  localparam int DCW = $clog2(VALUE_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LEN,
    S_RD,
    S_CH,
    S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [QW-1:0]     q_q, q_d;
  logic [3:0]        rem_q, rem_d;
  logic [CHW-1:0]    chunk_q, chunk_d;
  logic [DCW-1:0]    dc_q, dc_d;
  logic [4:0]        base_q, base_d;
  logic [5:0]        mw_q, mw_d;
  logic [6:0]        bs_q, bs_d;
  logic              neg_q, neg_d;
  logic [LEN_W-1:0]  total_q, total_d;
  logic [LEN_W-1:0]  limit_q, limit_d;
  logic [LEN_W-1:0]  dstart_q, dstart_d;
  logic [LEN_W-1:0]  p_q, p_d;

  // output register
  logic              ov_q, ov_d;
  logic [CHAR_W-1:0] oc_q, oc_d;
  logic              ocv_q, ocv_d;
  logic [5:0]        ofl_q, ofl_d;
  logic              olast_q, olast_d;

  logic                  in_acc;
  logic                  oslot;
  logic                  neg_w;
  logic [VALUE_BITS-1:0] mag_w;
  logic [QW-1:0]         qdiv;
  logic [3:0]            rdiv;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [3:0]            ram_rdata;
  logic [LEN_W-1:0]      daddr_w;

  // sizing results
  logic [LEN_W-1:0] dc_l, mw_l, neg_l, padded_w, total_w, bsm1_w, limit_w;

  assign in_acc   = in_i.valid && in_i.ready;
  assign oslot    = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // magnitude of the request value
  assign neg_w = in_i.operation && in_i.value[VALUE_BITS-1];
  assign mag_w = neg_w ? (VALUE_BITS'(0) - in_i.value) : in_i.value;

  // shared divide unit: four restoring steps of the long division by base
  always_comb begin
    logic [3:0]    r;
    logic [4:0]    r5;
    logic [QW-1:0] qw;
    r  = rem_q;
    qw = q_q;
    for (int i = 0; i < 4; i++) begin
      r5 = {r, qw[QW-1]};
      qw = {qw[QW-2:0], 1'b0};
      if (r5 >= base_q) begin
        r5    = r5 - base_q;
        qw[0] = 1'b1;
      end
      r = r5[3:0];
    end
    qdiv = qw;
    rdiv = r;
  end

  // string sizing from digit count, sign, width and buffer size
  always_comb begin
    dc_l     = LEN_W'(dc_q);
    mw_l     = LEN_W'(mw_q);
    neg_l    = LEN_W'(neg_q);
    padded_w = (mw_l > dc_l + neg_l) ? (mw_l - neg_l) : dc_l;
    total_w  = neg_l + padded_w;
    bsm1_w   = LEN_W'(bs_q) - LEN_W'(1);
    if (bs_q == '0) begin
      limit_w = '0;
    end else begin
      limit_w = (total_w < bsm1_w) ? total_w : bsm1_w;
    end
  end

  // digits sit least significant first, so position p reads entry total-1-p
  assign daddr_w   = total_q - LEN_W'(1) - p_q;
  assign ram_raddr = daddr_w[AW-1:0];
  assign ram_waddr = dc_q[AW-1:0];

  itoa_ram #(
    .WIDTH (4),
    .DEPTH (VALUE_BITS)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rdiv),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    q_d      = q_q;
    rem_d    = rem_q;
    chunk_d  = chunk_q;
    dc_d     = dc_q;
    base_d   = base_q;
    mw_d     = mw_q;
    bs_d     = bs_q;
    neg_d    = neg_q;
    total_d  = total_q;
    limit_d  = limit_q;
    dstart_d = dstart_q;
    p_d      = p_q;
    ram_we   = 1'b0;

    ov_d    = ov_q && !out_o.ready;
    oc_d    = oc_q;
    ocv_d   = ocv_q;
    ofl_d   = ofl_q;
    olast_d = olast_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          neg_d   = neg_w;
          q_d     = QW'(mag_w);
          rem_d   = '0;
          chunk_d = CHW'(NCH - 1);
          dc_d    = '0;
          if (in_i.base < BASE_MIN) begin
            base_d = BASE_MIN;
          end else if (in_i.base > BASE_MAX) begin
            base_d = BASE_MAX;
          end else begin
            base_d = in_i.base;
          end
          mw_d    = (in_i.pad_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : in_i.pad_width;
          bs_d    = in_i.buf_size;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        q_d   = qdiv;
        rem_d = rdiv;
        if (chunk_q == '0) begin
          // digit done: store the remainder, restart on the quotient
          ram_we  = 1'b1;
          dc_d    = dc_q + DCW'(1);
          rem_d   = '0;
          chunk_d = CHW'(NCH - 1);
          if (qdiv == '0 || dc_q == DCW'(VALUE_BITS - 1)) begin
            state_d = S_LEN;
          end
        end else begin
          chunk_d = chunk_q - CHW'(1);
        end
      end
      S_LEN: begin
        total_d  = total_w;
        limit_d  = limit_w;
        dstart_d = total_w - dc_l;
        p_d      = '0;
        state_d  = S_RD;
      end
      S_RD: begin
        state_d = (p_q == limit_q) ? S_FIN : S_CH;
      end
      S_CH: begin
        if (oslot) begin
          ov_d    = 1'b1;
          ocv_d   = 1'b1;
          ofl_d   = '0;
          olast_d = 1'b0;
          if (neg_q && p_q == '0) begin
            oc_d = CH_MINUS;
          end else if (p_q < dstart_q) begin
            oc_d = CH_ZERO;
          end else begin
            oc_d = glyph(ram_rdata);
          end
          p_d     = p_q + LEN_W'(1);
          state_d = S_RD;
        end
      end
      S_FIN: begin
        if (oslot) begin
          ov_d    = 1'b1;
          oc_d    = CH_NUL;
          ocv_d   = (bs_q != '0);
          ofl_d   = total_q[5:0];
          olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      q_q      <= '0;
      rem_q    <= '0;
      chunk_q  <= '0;
      dc_q     <= '0;
      base_q   <= BASE_MIN;
      mw_q     <= '0;
      bs_q     <= '0;
      neg_q    <= 1'b0;
      total_q  <= '0;
      limit_q  <= '0;
      dstart_q <= '0;
      p_q      <= '0;
      ov_q     <= 1'b0;
      oc_q     <= '0;
      ocv_q    <= 1'b0;
      ofl_q    <= '0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      q_q      <= q_d;
      rem_q    <= rem_d;
      chunk_q  <= chunk_d;
      dc_q     <= dc_d;
      base_q   <= base_d;
      mw_q     <= mw_d;
      bs_q     <= bs_d;
      neg_q    <= neg_d;
      total_q  <= total_d;
      limit_q  <= limit_d;
      dstart_q <= dstart_d;
      p_q      <= p_d;
      ov_q     <= ov_d;
      oc_q     <= oc_d;
      ocv_q    <= ocv_d;
      ofl_q    <= ofl_d;
      olast_q  <= olast_d;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.out_char    = oc_q;
  assign out_o.char_valid  = ocv_q;
  assign out_o.full_length = ofl_q;
  assign out_o.last        = olast_q;

  // checks
  `ITOA_ASSERT(a_accept_starts_div, in_acc |=> (state_q == S_DIV), "accept did not start division")
  `ITOA_ASSERT(a_emit_in_range, (state_q == S_RD || state_q == S_CH) |-> (p_q <= limit_q), "emit position past limit")
  `ITOA_ASSERT(a_digit_count_bounded, (state_q == S_LEN) |-> (dc_q != '0 && dc_q <= DCW'(VALUE_BITS)), "digit count out of range")
  `ITOA_ASSERT_NEVER(a_body_item_flags, ov_q && !olast_q && (!ocv_q || ofl_q != '0), "character item with bad flags")

endmodule

### tb/tb_integer_to_radix_ascii.sv
`timescale 1ns / 1ps
// self-checking testbench for integer_to_radix_ascii: directed and random conversions
// depends on itoa_pkg, itoa_in_if and itoa_out_if from the design folder
module tb_integer_to_radix_ascii
  import itoa_pkg::*;
;

  localparam int MAX_W     = 32;
  localparam int VAL_W     = 32;
  localparam int RST_LEN   = 8;
  localparam int HOLD_LEN  = 700;   // long receiver hold-off, well past one conversion
  localparam int IDLE_MAX  = 5000;  // watchdog limit on cycles with no item moving
  localparam int TAIL_LEN  = 400;   // quiet cycles after the last result, longer than one worst conversion
  localparam int PRINT_MAX = 200;

  typedef enum bit {
    OP_UNSIGNED = 1'b0,
    OP_SIGNED   = 1'b1
  } conv_op_e;

  // one conversion request as driven on the input channel
  typedef struct packed {
    conv_op_e          op;
    logic [VAL_W-1:0]  value;
    logic [4:0]        base;
    logic [5:0]        pad_width;
    logic [6:0]        buf_size;
  } request_t;

  // one character item as seen on the output channel
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              char_valid;
    logic [5:0]        full_length;
    logic              last;
  } char_item_t;

  // scoreboard: renders each accepted request into the character items it must
  // produce, then matches the output stream against them in order
  class text_scoreboard;
    char_item_t expected_text[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_text.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_MAX) begin
        $display("[%0t] mismatch: %s", $realtime, what);
      end
    endtask

    // render one request: sign, zero padding, digits msd first, cut, terminator
    function void note_request(request_t r);
      string             glyph_set;
      int unsigned       rad;
      int                wid, cap, sgn, ndig, padded, total, pads, lim, idx, d;
      logic [VAL_W-1:0]  mag;
      logic [3:0]        dig [VAL_W];
      char_item_t        c;
      glyph_set = "0123456789abcdef";
      rad = r.base;
      if (rad < 2) rad = 2;
      if (rad > 16) rad = 16;
      wid = r.pad_width;
      if (wid > MAX_W) wid = MAX_W;
      cap = r.buf_size;
      sgn = (r.op == OP_SIGNED && r.value[VAL_W-1]) ? 1 : 0;
      mag = (sgn == 1) ? ({VAL_W{1'b0}} - r.value) : r.value;
      ndig = 0;
      // digits come out least significant first
      do begin
        dig[ndig] = 4'(mag % rad);
        ndig++;
        mag = mag / rad;
      end while (mag != 0 && ndig < VAL_W);
      padded = (wid - sgn > ndig) ? wid - sgn : ndig;
      total  = sgn + padded;
      pads   = padded - ndig;
      lim    = 0;
      if (cap > 0) lim = (total < cap - 1) ? total : cap - 1;
      for (int p = 0; p < lim; p++) begin
        if (sgn == 1 && p == 0) begin
          c.ch = CH_MINUS;
        end else begin
          idx = p - sgn;
          if (idx < pads) begin
            c.ch = CH_ZERO;
          end else begin
            d = ndig - 1 - (idx - pads);
            c.ch = glyph_set[dig[d]];
          end
        end
        c.char_valid  = 1'b1;
        c.full_length = '0;
        c.last        = 1'b0;
        expected_text.push_back(c);
      end
      c.ch          = CH_NUL;
      c.char_valid  = (cap > 0);
      c.full_length = 6'(total);
      c.last        = 1'b1;
      expected_text.push_back(c);
    endfunction

    task check_result(char_item_t got);
      char_item_t want;
      if (expected_text.size() == 0) begin
        report($sformatf("unexpected item ch=%h cv=%b len=%0d last=%b",
                         got.ch, got.char_valid, got.full_length, got.last));
      end else begin
        want = expected_text.pop_front();
        if (got !== want) begin
          report($sformatf("ch %h/%h cv %b/%b len %0d/%0d last %b/%b (got/exp)",
                           got.ch, want.ch, got.char_valid, want.char_valid,
                           got.full_length, want.full_length, got.last, want.last));
        end
      end
    endtask

    task check_drained();
      if (expected_text.size() != 0) begin
        report($sformatf("%0d items never arrived", expected_text.size()));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  itoa_in_if #(.VALUE_BITS(VAL_W)) req_ch ();
  itoa_out_if                      txt_ch ();

  integer_to_radix_ascii #(
    .MAX_WIDTH (MAX_W),
    .VALUE_BITS(VAL_W)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch),
    .out_o (txt_ch)
  );

  text_scoreboard sb = new();

  // percentages of cycles in which each side holds back
  int send_idle_pct;
  int recv_stall_pct;
  // request for a long hold-off, picked up and counted by the receiver
  bit hold_go;
  int hold_left;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: decides ready at each falling edge
  initial begin
    txt_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        txt_ch.ready = 1'b0;
        hold_left--;
      end else begin
        txt_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // output monitor: every accepted item goes to the scoreboard
  always @(posedge clk_i) begin
    char_item_t got;
    got.ch          = txt_ch.out_char;
    got.char_valid  = txt_ch.char_valid;
    got.full_length = txt_ch.full_length;
    got.last        = txt_ch.last;
    if (rst_ni === 1'b1 && txt_ch.valid === 1'b1 && txt_ch.ready === 1'b1) begin
      sb.check_result(got);
    end
  end

  // watchdog: gives up when neither channel has moved an item for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_MAX) begin
      @(posedge clk_i);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (txt_ch.valid === 1'b1 && txt_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] watchdog: no progress for %0d cycles", $realtime, IDLE_MAX);
    $display("Verification failed");
    $finish;
  end

  function automatic request_t make_req(conv_op_e op, logic [VAL_W-1:0] value,
                                        logic [4:0] base, logic [5:0] pad_width,
                                        logic [6:0] buf_size);
    request_t r;
    r.op        = op;
    r.value     = value;
    r.base      = base;
    r.pad_width = pad_width;
    r.buf_size  = buf_size;
    return r;
  endfunction

  // random request, weighted toward legal bases and sizes with some out of range
  function automatic request_t random_req();
    request_t r;
    r.op = conv_op_e'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0: r.value = $urandom;
      1: r.value = $urandom_range(0, 40);
      2: r.value = -$urandom_range(1, 300);
      3: begin
        case ($urandom_range(0, 4))
          0: r.value = '0;
          1: r.value = 32'h0000_0001;
          2: r.value = 32'h7fff_ffff;
          3: r.value = 32'h8000_0000;
          default: r.value = 32'hffff_ffff;
        endcase
      end
      default: r.value = $urandom >> $urandom_range(0, 31);
    endcase
    r.base      = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(2, 16));
    r.pad_width = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 34));
    case ($urandom_range(0, 7))
      0:       r.buf_size = 7'($urandom_range(0, 127));
      1:       r.buf_size = 7'($urandom_range(0, 2));
      default: r.buf_size = 7'($urandom_range(0, 64));
    endcase
    return r;
  endfunction

  // offer one request; entered and left at a falling edge, valid stays up
  // after acceptance until the next call decides
  task send_request(request_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid     = 1'b1;
    req_ch.operation = r.op;
    req_ch.value     = r.value;
    req_ch.base      = r.base;
    req_ch.pad_width = r.pad_width;
    req_ch.buf_size  = r.buf_size;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  // stop offering and wait for every expected item to come back
  task wait_drained();
    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task send_random(int count);
    repeat (count) send_request(random_req());
  endtask

  initial begin
    request_t directed [$];

    rst_ni           = 1'b0;
    hold_go          = 1'b0;
    send_idle_pct    = 14;
    recv_stall_pct   = 84;
    req_ch.valid     = 1'b0;
    req_ch.operation = 1'b0;
    req_ch.value     = '0;
    req_ch.base      = '0;
    req_ch.pad_width = '0;
    req_ch.buf_size  = '0;
    repeat (RST_LEN) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part: zero, tiny buffers, sign cut, padding, extremes, bad bases
    directed.push_back(make_req(OP_UNSIGNED, 32'd0,         5'd10, 6'd0,  7'd64));
    directed.push_back(make_req(OP_UNSIGNED, 32'd0,         5'd10, 6'd0,  7'd0));
    directed.push_back(make_req(OP_UNSIGNED, 32'd12345,     5'd10, 6'd0,  7'd1));
    directed.push_back(make_req(OP_SIGNED,   -32'sd5,       5'd10, 6'd0,  7'd2));
    directed.push_back(make_req(OP_SIGNED,   -32'sd5,       5'd10, 6'd0,  7'd1));
    directed.push_back(make_req(OP_SIGNED,   -32'sd42,      5'd10, 6'd8,  7'd64));
    directed.push_back(make_req(OP_UNSIGNED, 32'hdeadbeef,  5'd16, 6'd0,  7'd64));
    directed.push_back(make_req(OP_UNSIGNED, 32'hffffffff,  5'd2,  6'd0,  7'd64));
    directed.push_back(make_req(OP_SIGNED,   32'h80000000,  5'd2,  6'd0,  7'd64));
    directed.push_back(make_req(OP_SIGNED,   32'h7fffffff,  5'd10, 6'd0,  7'd64));
    directed.push_back(make_req(OP_SIGNED,   32'hffffffff,  5'd16, 6'd0,  7'd64));
    directed.push_back(make_req(OP_UNSIGNED, 32'hffffffff,  5'd10, 6'd63, 7'd127));
    directed.push_back(make_req(OP_SIGNED,   32'hffffffff,  5'd8,  6'd40, 7'd20));
    directed.push_back(make_req(OP_UNSIGNED, 32'd255,       5'd0,  6'd0,  7'd64));
    directed.push_back(make_req(OP_UNSIGNED, 32'd255,       5'd1,  6'd0,  7'd64));
    directed.push_back(make_req(OP_UNSIGNED, 32'd255,       5'd17, 6'd0,  7'd64));
    directed.push_back(make_req(OP_UNSIGNED, 32'hffffffff,  5'd31, 6'd0,  7'd64));
    directed.push_back(make_req(OP_UNSIGNED, 32'd35,        5'd3,  6'd5,  7'd4));
    directed.push_back(make_req(OP_SIGNED,   32'd100,       5'd7,  6'd6,  7'd64));
    directed.push_back(make_req(OP_UNSIGNED, 32'd0,         5'd16, 6'd32, 7'd33));
    directed.push_back(make_req(OP_SIGNED,   32'h80000000,  5'd16, 6'd0,  7'd3));
    directed.push_back(make_req(OP_UNSIGNED, 32'd123456789, 5'd12, 6'd0,  7'd127));
    foreach (directed[i]) send_request(directed[i]);

    // phase one: sender mostly busy, receiver mostly stalled
    send_random(40);
    // long hold-off while the sender keeps offering, so the input backs up
    hold_go = 1'b1;
    send_random(5);
    // sender pause until everything has come back
    wait_drained();
    send_random(32);

    // phase two: sender mostly idle, receiver mostly ready
    send_idle_pct  = 84;
    recv_stall_pct = 14;
    send_random(77);

    // phase three: full rate on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random(54);

    // end of stimulus: drain, then watch for stray items
    wait_drained();
    repeat (TAIL_LEN) @(posedge clk_i);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
